@@ hdl/tlpb_pkg.sv @@
package tlpb_pkg;

    localparam int DEF_PANEL_COLS = 16;
    localparam int DEF_PANEL_ROWS = 16;
    localparam int COLOR_W = 24;
    localparam int COORD_W = 8;
    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_SET         = 3'd0,
        OP_CLEAR_PIX   = 3'd1,
        OP_QUERY       = 3'd2,
        OP_CLEAR_LAYER = 3'd3,
        OP_ROW_FALL    = 3'd4,
        OP_HLINE       = 3'd5,
        OP_VLINE       = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_FALL,
        ST_LINE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic init;
        logic clear;
        logic fall;
        logic line;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic advance;
        logic cnt_zero;
    } stat_t;

endpackage

@@ hdl/tlpb_ctrl.sv @@
module tlpb_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [tlpb_pkg::OP_W-1:0]       operation,
    input  tlpb_pkg::stat_t                 stat,
    output logic                            in_stall,
    output tlpb_pkg::cmd_t                  cmd
);
    import tlpb_pkg::*;

    state_t state_reg;
    state_t state_next;
    op_t    op;
    logic   accept;

    assign op     = op_t'(operation);
    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_CLEAR_LAYER: state_next = ST_CLEAR;
                        OP_ROW_FALL:    state_next = ST_FALL;
                        OP_HLINE:       state_next = ST_LINE;
                        OP_VLINE:       state_next = ST_LINE;
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT, ST_CLEAR, ST_FALL, ST_LINE:
            begin
                // A row fall's last copy is written in the cycle the count reads zero.
                if (stat.cnt_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE) || !stat.advance;
        cmd.accept = accept;
        cmd.init   = 1'b0;
        cmd.clear  = 1'b0;
        cmd.fall   = 1'b0;
        cmd.line   = 1'b0;
        case (state_reg)
            ST_INIT:  cmd.init  = 1'b1;
            ST_CLEAR: cmd.clear = 1'b1;
            ST_FALL:  cmd.fall  = 1'b1;
            ST_LINE:  cmd.line  = 1'b1;
            default:  cmd.init  = 1'b0;
        endcase
    end

endmodule

@@ hdl/tlpb_datapath.sv @@
module tlpb_datapath #(
    parameter int PANEL_COLS = tlpb_pkg::DEF_PANEL_COLS,
    parameter int PANEL_ROWS = tlpb_pkg::DEF_PANEL_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlpb_pkg::cmd_t                  cmd,
    output tlpb_pkg::stat_t                 stat,
    input  logic [tlpb_pkg::OP_W-1:0]       operation,
    input  logic                            layer,
    input  logic [tlpb_pkg::COORD_W-1:0]    col,
    input  logic [tlpb_pkg::COORD_W-1:0]    row,
    input  logic [tlpb_pkg::COORD_W-1:0]    length,
    input  logic [tlpb_pkg::COLOR_W-1:0]    color,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic                            layer_set,
    output logic                            pixel_on,
    output logic [tlpb_pkg::COLOR_W-1:0]    pixel_color
);
    import tlpb_pkg::*;

    localparam int CELLS   = PANEL_COLS * PANEL_ROWS;
    localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CELL_CW = $clog2(CELLS + 1);
    localparam int CNT_W   = (CELL_CW > COORD_W) ? CELL_CW : COORD_W;
    localparam int POS_W   = COORD_W + 1;
    localparam int PROD_W  = 2 * COORD_W + 1;
    localparam int ENTRY_W = COLOR_W + 1;

    localparam logic [POS_W-1:0]  COLS_LIM  = POS_W'(PANEL_COLS);
    localparam logic [POS_W-1:0]  ROWS_LIM  = POS_W'(PANEL_ROWS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(PANEL_COLS);
    localparam logic [CNT_W-1:0]  CELLS_CNT = CNT_W'(CELLS);
    localparam logic [PROD_W-1:0] COLS_MUL  = PROD_W'(PANEL_COLS);

    // Bit COLOR_W of an entry is the opaque flag.
    logic [ENTRY_W-1:0] bg_mem [CELLS];
    logic [ENTRY_W-1:0] fg_mem [CELLS];
    logic [ENTRY_W-1:0] bg_rd_reg;
    logic [ENTRY_W-1:0] fg_rd_reg;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               pend_reg, pend_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               out_valid_reg, out_valid_next;

    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [POS_W-1:0]   x_reg, x_next;
    logic [POS_W-1:0]   y_reg, y_next;
    logic               layer_reg, layer_next;
    logic               vert_reg, vert_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               s1_query_reg, s1_query_next;
    logic               s1_on_reg, s1_on_next;
    logic               s1_sel_reg, s1_sel_next;
    logic               layer_set_reg, layer_set_next;
    logic               pixel_on_reg, pixel_on_next;
    logic [COLOR_W-1:0] pixel_color_reg, pixel_color_next;

    op_t                op;
    logic [PROD_W-1:0]  row_base;
    logic [PROD_W-1:0]  pix_lin;
    logic [ADDR_W-1:0]  pix_addr;
    logic               on_panel;
    logic               row_ok;
    logic               line_on;
    logic               step;
    logic               advance;
    logic               we_bg, we_fg, re;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [ENTRY_W-1:0] wdata;
    logic               hit;
    logic               fg_op, bg_op;

    assign op       = op_t'(operation);
    assign row_base = PROD_W'(row) * COLS_MUL;
    assign pix_lin  = row_base + PROD_W'(col);
    assign pix_addr = pix_lin[ADDR_W-1:0];
    assign row_ok   = {1'b0, row} < ROWS_LIM;
    assign on_panel = ({1'b0, col} < COLS_LIM) && row_ok;
    assign line_on  = (x_reg < COLS_LIM) && (y_reg < ROWS_LIM);
    assign step     = cnt_reg != '0;
    assign advance  = !out_valid_reg || !out_stall;

    assign stat.advance  = advance;
    assign stat.cnt_zero = !step;

    // Sweep counters and addresses.
    always_comb
    begin
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        pend_next      = cmd.fall && step;
        pend_addr_next = pend_addr_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        layer_next     = layer_reg;
        vert_next      = vert_reg;
        color_next     = color_reg;
        if (cmd.accept)
        begin
            layer_next = layer;
            color_next = color;
            x_next     = {1'b0, col};
            y_next     = {1'b0, row};
            vert_next  = (op == OP_VLINE);
            case (op)
                OP_CLEAR_LAYER:
                begin
                    cnt_next  = CELLS_CNT;
                    addr_next = '0;
                end
                OP_ROW_FALL:
                begin
                    // The walk runs from the last entry of the named row's upper
                    // neighbor down to entry zero, each copied one row lower.
                    cnt_next  = row_ok ? CNT_W'(row_base) : '0;
                    addr_next = ADDR_W'(row_base - PROD_W'(1));
                end
                OP_HLINE, OP_VLINE:
                begin
                    cnt_next  = CNT_W'(length);
                    addr_next = pix_addr;
                end
                default:
                begin
                    cnt_next = '0;
                end
            endcase
        end
        else if (step)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cmd.fall)
            begin
                addr_next      = addr_reg - ADDR_W'(1);
                pend_addr_next = addr_reg + ROW_STEP;
            end
            else if (cmd.line && vert_reg)
            begin
                addr_next = addr_reg + ROW_STEP;
                y_next    = y_reg + POS_W'(1);
            end
            else if (cmd.line)
            begin
                addr_next = addr_reg + ADDR_W'(1);
                x_next    = x_reg + POS_W'(1);
            end
            else
            begin
                addr_next = addr_reg + ADDR_W'(1);
            end
        end
    end

    // Memory port selection.
    always_comb
    begin
        we_bg = 1'b0;
        we_fg = 1'b0;
        waddr = addr_reg;
        wdata = '0;
        if (cmd.accept)
        begin
            waddr = pix_addr;
            wdata = (op == OP_SET) ? {1'b1, color} : '0;
            if (on_panel && ((op == OP_SET) || (op == OP_CLEAR_PIX)))
            begin
                we_bg = !layer;
                we_fg = layer;
            end
        end
        else if (cmd.init && step)
        begin
            we_bg = 1'b1;
            we_fg = 1'b1;
        end
        else if (cmd.clear && step)
        begin
            we_bg = !layer_reg;
            we_fg = layer_reg;
        end
        else if (cmd.line && step && line_on)
        begin
            wdata = {1'b1, color_reg};
            we_bg = !layer_reg;
            we_fg = layer_reg;
        end
        else if (pend_reg)
        begin
            waddr = pend_addr_reg;
            wdata = layer_reg ? fg_rd_reg : bg_rd_reg;
            we_bg = !layer_reg;
            we_fg = layer_reg;
        end
    end

    assign re    = (cmd.accept && (op == OP_QUERY)) || (cmd.fall && step);
    assign raddr = cmd.accept ? pix_addr : addr_reg;

    always_ff @(posedge clk)
    begin
        if (we_bg)
        begin
            bg_mem[waddr] <= wdata;
        end
        if (we_fg)
        begin
            fg_mem[waddr] <= wdata;
        end
        if (re)
        begin
            bg_rd_reg <= bg_mem[raddr];
            fg_rd_reg <= fg_mem[raddr];
        end
    end

    // Result pipeline: the request stage waits for the read data, then the
    // composited result sits in the output register until it is taken.
    assign fg_op = fg_rd_reg[COLOR_W];
    assign bg_op = bg_rd_reg[COLOR_W];
    assign hit   = s1_valid_reg && s1_query_reg && s1_on_reg;

    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        s1_query_next    = s1_query_reg;
        s1_on_next       = s1_on_reg;
        s1_sel_next      = s1_sel_reg;
        out_valid_next   = out_valid_reg;
        layer_set_next   = layer_set_reg;
        pixel_on_next    = pixel_on_reg;
        pixel_color_next = pixel_color_reg;
        if (cmd.accept)
        begin
            s1_query_next = (op == OP_QUERY);
            s1_on_next    = on_panel;
            s1_sel_next   = layer;
        end
        if (advance)
        begin
            s1_valid_next  = cmd.accept;
            out_valid_next = s1_valid_reg;
            layer_set_next = hit && (s1_sel_reg ? fg_op : bg_op);
            pixel_on_next  = hit && (fg_op || bg_op);
            if (!hit)
            begin
                pixel_color_next = '0;
            end
            else if (fg_op)
            begin
                pixel_color_next = fg_rd_reg[COLOR_W-1:0];
            end
            else if (bg_op)
            begin
                pixel_color_next = bg_rd_reg[COLOR_W-1:0];
            end
            else
            begin
                pixel_color_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= CELLS_CNT;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg   <= pend_addr_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        layer_reg       <= layer_next;
        vert_reg        <= vert_next;
        color_reg       <= color_next;
        s1_query_reg    <= s1_query_next;
        s1_on_reg       <= s1_on_next;
        s1_sel_reg      <= s1_sel_next;
        layer_set_reg   <= layer_set_next;
        pixel_on_reg    <= pixel_on_next;
        pixel_color_reg <= pixel_color_next;
    end

    assign out_valid   = out_valid_reg;
    assign layer_set   = layer_set_reg;
    assign pixel_on    = pixel_on_reg;
    assign pixel_color = pixel_color_reg;

endmodule

@@ hdl/two_layer_pixel_buffer.sv @@
// Two-layer pixel buffer with transparency, PANEL_COLS x PANEL_ROWS entries per layer.
// The input channel (in_valid/in_stall) carries one request: operation, layer,
// col, row, length and color. Every request returns exactly one result on the
// output channel (out_valid/out_stall); only a query returns nonzero fields.
// Set pixel, clear pixel and query are taken one per cycle while no result is held
// on a stalled output. A result passes from the request stage, which waits for the
// registered read port of the layer memories, into the output register.
// Bulk requests walk the memories one entry per cycle and hold in_stall high:
// clear layer walks all PANEL_COLS*PANEL_ROWS entries, row fall walks the
// row*PANEL_COLS entries above the named row, and a line fill walks length entries.
// After reset both layers are cleared by a pass over all PANEL_COLS*PANEL_ROWS
// entries, during which in_stall is high.
// When the receiver raises out_stall while a result waits, the result is held and
// in_stall rises in the same cycle, so no request is taken until the result leaves.
module two_layer_pixel_buffer #(
    parameter int PANEL_COLS = tlpb_pkg::DEF_PANEL_COLS,
    parameter int PANEL_ROWS = tlpb_pkg::DEF_PANEL_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tlpb_pkg::OP_W-1:0]       operation,
    input  logic                            layer,
    input  logic [tlpb_pkg::COORD_W-1:0]    col,
    input  logic [tlpb_pkg::COORD_W-1:0]    row,
    input  logic [tlpb_pkg::COORD_W-1:0]    length,
    input  logic [tlpb_pkg::COLOR_W-1:0]    color,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            layer_set,
    output logic                            pixel_on,
    output logic [tlpb_pkg::COLOR_W-1:0]    pixel_color
);
    import tlpb_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tlpb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .stat      (stat),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    tlpb_datapath #(
        .PANEL_COLS (PANEL_COLS),
        .PANEL_ROWS (PANEL_ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .layer       (layer),
        .col         (col),
        .row         (row),
        .length      (length),
        .color       (color),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .layer_set   (layer_set),
        .pixel_on    (pixel_on),
        .pixel_color (pixel_color)
    );

endmodule

@@ hdl/tlpb_checker.sv @@
module tlpb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [tlpb_pkg::OP_W-1:0]       operation,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            layer_set,
    input logic                            pixel_on,
    input logic [tlpb_pkg::COLOR_W-1:0]    pixel_color
);
    import tlpb_pkg::*;

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    // Anything but a query reports an all-zero result.
    a_non_query_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (operation != OP_QUERY)) ##1 !out_stall |=>
        (out_valid && !layer_set && !pixel_on && (pixel_color == '0)))
        else $error("non-query request produced a nonzero result");

    // An unlit pixel cannot have its chosen layer opaque or carry a color.
    a_unlit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pixel_on) |-> (!layer_set && (pixel_color == '0)))
        else $error("unlit result carries layer flag or color");

    // A bulk request holds off the next request while the store is walked.
    a_bulk_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && ((operation == OP_CLEAR_LAYER) || (operation == OP_ROW_FALL) ||
                    (operation == OP_HLINE) || (operation == OP_VLINE)))
        |=> in_stall)
        else $error("request taken right after a bulk request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(pixel_color) && $stable(pixel_on) && $stable(layer_set)))
        else $error("stalled result changed");

endmodule

bind two_layer_pixel_buffer tlpb_checker u_tlpb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .layer_set   (layer_set),
    .pixel_on    (pixel_on),
    .pixel_color (pixel_color)
);
